@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks sampled on clk, off while rst is high
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checks sampled on clk, also during reset
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/srfm_pkg.sv @@
`timescale 1ns / 1ps

package srfm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LEN_REG_W   = 5;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);

  // one queued command: what a single input byte makes the back end send
  typedef struct packed {
    logic                        head_en;
    logic [7:0]                  head_byte;
    logic                        rep_en;
    logic                        tail_en;
    logic [7:0]                  tail_byte;
    logic [CNT_W-1:0]            flush_cnt;
    logic [PATTERN_MAX-1:0][7:0] flush_bytes;
    logic                        eol;
  } cmd_t;

  function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_REG_W-1:0] v);
    return (v > LEN_REG_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : CNT_W'(v);
  endfunction

endpackage

@@ hdl/srfm_front.sv @@
`timescale 1ns / 1ps

module srfm_front import srfm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // line_byte
  input  logic                        s_tlast,
  input  logic [PATTERN_MAX-1:0][7:0] pattern,
  input  logic [LEN_REG_W-1:0]        pattern_len,
  input  logic [LEN_REG_W-1:0]        replacement_len,
  input  logic                        full,
  output logic                        push,
  output cmd_t                        push_cmd
);

  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0][7:0] win_next;
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;
  logic                        replaced;
  logic                        replaced_next;

  logic [PATTERN_MAX-1:0][7:0] app;
  logic [PATTERN_MAX-1:0][7:0] app_up;
  logic [PATTERN_MAX-1:0][7:0] win_up;
  logic [PATTERN_MAX-1:0][7:0] sh;
  logic [CNT_W-1:0]            p;
  logic [CNT_W-1:0]            r;
  logic                        hit;
  logic                        accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && !full;
  assign p        = clamp_len(pattern_len);
  assign r        = clamp_len(replacement_len);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      app[i] = (CNT_W'(i) == cnt) ? s_tdata : win[i];
    end
    win_up = {s_tdata, win[PATTERN_MAX-1:1]};
    app_up = {s_tdata, app[PATTERN_MAX-1:1]};
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sh[i] = (CNT_W'(i + 1) == cnt) ? s_tdata : win_up[i];
    end
    hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < p) && (app[i] != pattern[i])) hit = 1'b0;
    end
  end

  always_comb begin
    win_next      = win;
    cnt_next      = cnt;
    replaced_next = replaced;
    push_cmd      = '0;
    push_cmd.head_byte = win[0];
    push_cmd.tail_byte = s_tdata;
    priority if (replaced) begin
      push_cmd.tail_en = 1'b1;
    end else if (cnt == '0 && p == '0) begin
      push_cmd.rep_en  = 1'b1;
      push_cmd.tail_en = 1'b1;
      replaced_next    = 1'b1;
    end else if (cnt >= p) begin
      // held bytes at least as many as the pattern: slide only
      push_cmd.head_en = 1'b1;
      win_next         = sh;
    end else if (cnt + CNT_W'(1) == p) begin
      if (hit) begin
        push_cmd.rep_en = 1'b1;
        cnt_next        = '0;
        replaced_next   = 1'b1;
      end else begin
        push_cmd.head_en   = 1'b1;
        push_cmd.head_byte = app[0];
        win_next           = app_up;
      end
    end else begin
      win_next = app;
      cnt_next = cnt + CNT_W'(1);
    end
    if (s_tlast) begin
      push_cmd.eol         = 1'b1;
      push_cmd.flush_bytes = win_next;
      push_cmd.flush_cnt   = cnt_next;
      cnt_next             = '0;
      replaced_next        = 1'b0;
    end
  end

  assign push = accept && (push_cmd.head_en || push_cmd.tail_en || push_cmd.eol ||
                           (push_cmd.rep_en && r != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      replaced <= 1'b0;
    end else if (accept) begin
      cnt      <= cnt_next;
      replaced <= replaced_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

@@ hdl/srfm_queue.sv @@
`timescale 1ns / 1ps

module srfm_queue import srfm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full     = (level == LVL_W'(DEPTH));
  assign empty    = (level == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/srfm_back.sv @@
`timescale 1ns / 1ps

module srfm_back import srfm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  cmd_t                        head_cmd,
  output logic                        pop,
  input  logic [PATTERN_MAX-1:0][7:0] replacement,
  input  logic [LEN_REG_W-1:0]        replacement_len,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // out_byte
  output logic                        m_tuser,   // byte_valid
  output logic                        m_tlast
);

  localparam int POS_W = $clog2(2 * PATTERN_MAX + 3);

  cmd_t             cur;
  logic             cur_valid;
  logic [POS_W-1:0] k;

  logic [POS_W-1:0] rr;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] len_eff;
  logic [POS_W-1:0] j;
  logic [POS_W-1:0] j2;
  logic [POS_W-1:0] j3;
  logic [7:0]       word_byte;
  logic             word_valid;
  logic             last_word;
  logic             produce;
  logic             load;

  always_comb begin
    rr      = cur.rep_en ? POS_W'(clamp_len(replacement_len)) : '0;
    total   = POS_W'(cur.head_en) + rr + POS_W'(cur.tail_en) + POS_W'(cur.flush_cnt);
    len_eff = (total == '0) ? POS_W'(1) : total;
    j       = k - POS_W'(cur.head_en);
    j2      = j - rr;
    j3      = j2 - POS_W'(cur.tail_en);
    word_valid = 1'b1;
    priority if (cur.head_en && k == '0) begin
      word_byte = cur.head_byte;
    end else if (j < rr) begin
      word_byte = replacement[j[IDX_W-1:0]];
    end else if (cur.tail_en && j2 == '0) begin
      word_byte = cur.tail_byte;
    end else if (total != '0) begin
      word_byte = cur.flush_bytes[j3[IDX_W-1:0]];
    end else begin
      // empty line end
      word_byte  = 8'd0;
      word_valid = 1'b0;
    end
  end

  assign last_word = (k == len_eff - POS_W'(1));
  assign produce   = cur_valid && (!m_tvalid || m_tready);
  assign load      = !cur_valid || (produce && last_word);
  assign pop       = load && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (produce) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        cur_valid <= !empty;
        k         <= '0;
      end else if (produce) begin
        k <= k + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
    if (produce) begin
      m_tdata <= word_byte;
      m_tuser <= word_valid;
      m_tlast <= cur.eol && last_word;
    end
  end

endmodule

@@ hdl/stream_replace_first_match.sv @@
`timescale 1ns / 1ps

// stream replacer for the first match of a pattern in each text line
// input stream s_*: one text byte per word in s_tdata, s_tlast on a line's last byte
// output stream m_*: m_tdata byte, m_tuser high for a real byte and low for an empty
//   line-end marker (data zero), m_tlast on the last word of each output line
// config: cfg_we writes cfg_data into register cfg_index (0 pattern_low,
//   1 pattern_high, 2 pattern_len, 3 replacement_low, 4 replacement_high,
//   5 replacement_len), lengths saturate at 16, write only while idle
// throughput: one input byte per cycle while m_tready is high and each byte yields
//   at most one word; a byte that yields more words (replacement, window flush) holds
//   the output sequencer until they are sent, and a queue of QUEUE_DEPTH commands
//   between the matcher and the sequencer absorbs these bursts before s_tready drops
// path: queue, then sequencer command register, then the m_* output register
// stall: when m_tready is low the output word holds, the queue fills, then
//   s_tready goes low
// reset: registers and line state clear, window count zero, queue and output empty

module stream_replace_first_match import srfm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // line_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH     = 3'd1;
  localparam logic [2:0] REG_PATTERN_LEN      = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LOW  = 3'd3;
  localparam logic [2:0] REG_REPLACEMENT_HIGH = 3'd4;
  localparam logic [2:0] REG_REPLACEMENT_LEN  = 3'd5;

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [LEN_REG_W-1:0] pattern_len;
  logic [63:0]          replacement_low;
  logic [63:0]          replacement_high;
  logic [LEN_REG_W-1:0] replacement_len;

  logic [PATTERN_MAX-1:0][7:0] pattern;
  logic [PATTERN_MAX-1:0][7:0] replacement;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic empty;
  cmd_t head_cmd;

  assign pattern     = {pattern_high, pattern_low};
  assign replacement = {replacement_high, replacement_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low      <= '0;
      pattern_high     <= '0;
      pattern_len      <= '0;
      replacement_low  <= '0;
      replacement_high <= '0;
      replacement_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:      pattern_low      <= cfg_data;
        REG_PATTERN_HIGH:     pattern_high     <= cfg_data;
        REG_PATTERN_LEN:      pattern_len      <= cfg_data[LEN_REG_W-1:0];
        REG_REPLACEMENT_LOW:  replacement_low  <= cfg_data;
        REG_REPLACEMENT_HIGH: replacement_high <= cfg_data;
        REG_REPLACEMENT_LEN:  replacement_len  <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  srfm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .pattern         (pattern),
    .pattern_len     (pattern_len),
    .replacement_len (replacement_len),
    .full            (full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  srfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_cmd (head_cmd)
  );

  srfm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .replacement     (replacement),
    .replacement_len (replacement_len),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast)
  );

endmodule

@@ hdl/srfm_checker.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module srfm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  `ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")
  `ASSERT_RUN(a_marker_form, m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'd0), "empty marker without line end or with data")
  `ASSERT_ANY(a_reset_out_empty, rst |=> !m_tvalid, "output word present right after reset")
  `ASSERT_ANY(a_reset_ready, rst |=> s_tready, "input not ready right after reset")

endmodule

bind stream_replace_first_match srfm_checker u_srfm_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import srfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [2:0] REG_PAT_LO  = 3'd0;
  localparam logic [2:0] REG_PAT_HI  = 3'd1;
  localparam logic [2:0] REG_PAT_LEN = 3'd2;
  localparam logic [2:0] REG_REP_LO  = 3'd3;
  localparam logic [2:0] REG_REP_HI  = 3'd4;
  localparam logic [2:0] REG_REP_LEN = 3'd5;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // line_byte
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // out_byte
  logic        m_tuser;   // byte_valid
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // shadow registers and line state of the replacer
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [4:0]  pat_len, rep_len;
  logic [7:0]  held [16];
  int          held_cnt;
  bit          line_replaced;

  out_word_t   expected_words[$];
  logic [7:0]  line_buf[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cnt;
  int items_sent;
  int mismatch_count;
  int cycle_count;

  stream_replace_first_match u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int used_len(logic [4:0] v);
    return (v > PATTERN_MAX) ? PATTERN_MAX : int'(v);
  endfunction

  function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int i);
    return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
  endfunction

  function automatic void release_oldest();
    expected_words.push_back('{held[0], 1'b1, 1'b0});
    for (int i = 1; i < held_cnt; i++)
      held[i-1] = held[i];
    held_cnt--;
  endfunction

  // expected words caused by one accepted byte
  function automatic void predict_byte(logic [7:0] b, logic eol);
    int  p, r, start;
    bit  hit;
    p = used_len(pat_len);
    r = used_len(rep_len);
    start = expected_words.size();
    if (line_replaced) begin
      expected_words.push_back('{b, 1'b1, 1'b0});
    end else if (held_cnt == 0 && p == 0) begin
      for (int i = 0; i < r; i++)
        expected_words.push_back('{byte_at(rep_lo, rep_hi, i), 1'b1, 1'b0});
      expected_words.push_back('{b, 1'b1, 1'b0});
      line_replaced = 1'b1;
    end else if (held_cnt >= p) begin
      // window already at least as long as the pattern: plain delay line
      release_oldest();
      held[held_cnt] = b;
      held_cnt++;
    end else begin
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt == p) begin
        hit = 1'b1;
        for (int i = 0; i < p; i++)
          if (held[i] != byte_at(pat_lo, pat_hi, i))
            hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < r; i++)
            expected_words.push_back('{byte_at(rep_lo, rep_hi, i), 1'b1, 1'b0});
          held_cnt = 0;
          line_replaced = 1'b1;
        end else begin
          release_oldest();
        end
      end
    end
    if (eol) begin
      for (int i = 0; i < held_cnt; i++)
        expected_words.push_back('{held[i], 1'b1, 1'b0});
      held_cnt = 0;
      if (expected_words.size() == start)
        expected_words.push_back('{8'h00, 1'b0, 1'b0});
      expected_words[expected_words.size()-1].last = 1'b1;
      line_replaced = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word data=%02h user=%0b last=%0b",
                                m_tdata, m_tuser, m_tlast));
      end else begin
        want = expected_words.pop_front();
        if (m_tdata !== want.data || m_tuser !== want.valid || m_tlast !== want.last)
          note_mismatch($sformatf("expected data=%02h user=%0b last=%0b, got data=%02h user=%0b last=%0b",
                                  want.data, want.valid, want.last, m_tdata, m_tuser, m_tlast));
      end
    end
  end

  // output side: long hold-off first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, eol);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i])
      send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_PAT_LO:  pat_lo  = value;
      REG_PAT_HI:  pat_hi  = value;
      REG_PAT_LEN: pat_len = value[4:0];
      REG_REP_LO:  rep_lo  = value;
      REG_REP_HI:  rep_hi  = value;
      REG_REP_LEN: rep_len = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct, input int hold);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    hold_cnt       = hold;
    @(negedge clk);
  endtask

  // negative length picks one at random, above 16 included
  task automatic random_config(input int plen, input int rlen);
    logic [127:0] pbytes;
    logic [63:0]  noise;
    for (int i = 0; i < PATTERN_MAX; i++)
      pbytes[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'h61 + 8'($urandom_range(0, 1));
    if (plen < 0) begin
      case ($urandom_range(0, 5))
        0: plen = 0;
        1: plen = 1;
        2, 3: plen = $urandom_range(2, 4);
        4: plen = $urandom_range(5, 16);
        default: plen = $urandom_range(17, 31);
      endcase
    end
    if (rlen < 0)
      rlen = $urandom_range(0, 31);
    write_reg(REG_PAT_LO, pbytes[63:0]);
    write_reg(REG_PAT_HI, pbytes[127:64]);
    noise = {$urandom, $urandom};
    write_reg(REG_PAT_LEN, (noise & 64'hFFFF_FFFF_FFFF_FFE0) | 64'(plen));
    write_reg(REG_REP_LO, {$urandom, $urandom});
    write_reg(REG_REP_HI, {$urandom, $urandom});
    noise = {$urandom, $urandom};
    write_reg(REG_REP_LEN, (noise & 64'hFFFF_FFFF_FFFF_FFE0) | 64'(rlen));
  endtask

  function automatic logic [7:0] near_byte(int p);
    if (p > 0 && $urandom_range(0, 1) == 1)
      return byte_at(pat_lo, pat_hi, $urandom_range(0, p - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly lines that hold the pattern, some near misses and plain noise
  function automatic void build_line();
    int p, kind, n;
    p = used_len(pat_len);
    kind = $urandom_range(0, 9);
    line_buf.delete();
    if (kind < 7) begin
      n = $urandom_range(0, 6);
      repeat (n) line_buf.push_back(near_byte(p));
      if (p > 1 && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, p - 1);
        for (int i = 0; i < n; i++)
          line_buf.push_back(byte_at(pat_lo, pat_hi, i));
      end
      for (int i = 0; i < p; i++)
        line_buf.push_back(byte_at(pat_lo, pat_hi, i));
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < p; i++)
          line_buf.push_back(byte_at(pat_lo, pat_hi, i));
      n = $urandom_range(0, 6);
      repeat (n) line_buf.push_back(near_byte(p));
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) line_buf.push_back((kind == 9) ? 8'($urandom_range(0, 255)) : near_byte(p));
    end
    if (line_buf.size() == 0)
      line_buf.push_back(near_byte(p));
  endfunction

  task automatic test_directed();
    set_idling(0, 0, 0);
    // reset values: empty pattern, empty replacement
    line_buf = {8'h00};
    send_line();
    line_buf = {8'hFF};
    send_line();
    wait_idle();
    write_reg(REG_PAT_LO, 64'h6261);
    write_reg(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd2);
    write_reg(REG_REP_LO, 64'h5A5958);
    write_reg(REG_REP_HI, 64'h0);
    write_reg(REG_REP_LEN, 64'd3);
    write_reg(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
    // second match passes through
    line_buf = {8'h63, 8'h61, 8'h62, 8'h61, 8'h62};
    send_line();
    // held byte flushed at line end
    line_buf = {8'h61};
    send_line();
    wait_idle();
    write_reg(REG_REP_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    // match with empty replacement leaves only the marker
    line_buf = {8'h61, 8'h62};
    send_line();
    wait_idle();
    write_reg(REG_REP_LEN, 64'd3);
    write_reg(REG_PAT_LO, 64'h636261);
    write_reg(REG_PAT_LEN, 64'd3);
    // pattern shortened while two bytes are held
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    wait_idle();
    write_reg(REG_PAT_LEN, 64'd1);
    line_buf = {8'hFF, 8'h61};
    send_line();
    wait_idle();
    write_reg(REG_PAT_LEN, 64'd2);
    // empty pattern while a byte is held: no insertion this line
    send_byte(8'h61, 1'b0);
    wait_idle();
    write_reg(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE3 & 64'hFFFF_FFFF_FFFF_FFE0);
    line_buf = {8'h62};
    send_line();
    line_buf = {8'h7A};
    send_line();
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    int target;
    random_config(1, 16);
    set_idling(0, 0, 300);
    target = items_sent + 30;
    while (items_sent < target) begin
      build_line();
      send_line();
    end
    wait_idle();
  endtask

  task automatic test_random_phase(input int send_pct, input int stall_pct,
                                   input int plen, input int rlen, input int n_items);
    int target;
    set_idling(send_pct, stall_pct, 0);
    for (int chunk = 0; chunk < 3; chunk++) begin
      wait_idle();
      if (chunk == 0)
        random_config(plen, rlen);
      else
        random_config(-1, -1);
      target = items_sent + n_items / 3;
      while (items_sent < target) begin
        build_line();
        send_line();
      end
    end
    wait_idle();
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    s_tlast        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PAT_LO;
    cfg_data       = 64'h0;
    pat_lo         = 64'h0;
    pat_hi         = 64'h0;
    pat_len        = 5'd0;
    rep_lo         = 64'h0;
    rep_hi         = 64'h0;
    rep_len        = 5'd0;
    held_cnt       = 0;
    line_replaced  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cnt       = 0;
    items_sent     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    foreach (held[i]) held[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_output_backpressure();
    test_random_phase(0, 0, 31, 16, 54);
    test_random_phase(72, 0, 0, 31, 54);
    test_random_phase(0, 72, 16, 0, 54);
    test_random_phase(20, 20, 1, 17, 54);

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0)
      note_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
